// ===== src/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, constants and helpers for the sysex frame checker.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int MAX_PAYLOAD = 4096;
    localparam int POS_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int HEADER_LEN  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_NIBBLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIX_MODE        = 2'd1;

    localparam logic [POS_W-1:0] PAYLOAD_RESET = 13'd672;
    localparam logic [POS_W-1:0] PAYLOAD_MIN   = 13'd2;
    localparam logic [POS_W-1:0] PAYLOAD_MAX   = POS_W'(MAX_PAYLOAD);

    localparam logic [7:0] END_MARK  = 8'hF7;
    localparam logic [7:0] CSUM_MASK = 8'h7F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_wrong;
        logic       frame_last;
        logic       frame_bad;
    } t_result;

    function automatic logic [7:0] header_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'hF0;
            3'd1:    b = 8'h44;
            3'd2:    b = 8'h03;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h70;
            3'd5:    b = 8'h00;
            3'd6:    b = 8'h40;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Clamp to [2, MAX_PAYLOAD] and force an even count.
    function automatic logic [POS_W-1:0] effective_payload(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] c;
        c = p;
        if (c < PAYLOAD_MIN) c = PAYLOAD_MIN;
        if (c > PAYLOAD_MAX) c = PAYLOAD_MAX;
        return {c[POS_W-1:1], 1'b0};
    endfunction

endpackage

// ===== src/sfc_frame_logic.sv =====
// ----------------------------------------------------------------------------
// sfc_frame_logic
// Frame position tracking, checksum accumulation and per-byte compare.
// ----------------------------------------------------------------------------
module sfc_frame_logic (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  sfc_pkg::t_item             i_item,
    input  logic [sfc_pkg::POS_W-1:0]  i_payload_nibbles,
    input  logic                       i_fix_mode,
    output sfc_pkg::t_result           o_result
);
    import sfc_pkg::*;

    logic [POS_W-1:0] r_position, n_position;
    logic [7:0]       r_running_sum, n_running_sum;
    logic [3:0]       r_held_high, n_held_high;
    logic             r_bad_seen, n_bad_seen;

    logic [POS_W-1:0] w_csum_pos;
    logic [POS_W-1:0] w_pos;
    logic [7:0]       w_sum;
    logic [3:0]       w_held;
    logic             w_bad;
    logic [7:0]       w_expected;
    logic             w_checked;
    logic             w_last;
    logic             w_wrong;

    assign w_csum_pos = POS_W'(HEADER_LEN) + effective_payload(i_payload_nibbles);

    always_comb begin
        // frame start clears the frame before this byte is handled
        w_pos  = i_item.frame_start ? '0 : r_position;
        w_sum  = i_item.frame_start ? '0 : r_running_sum;
        w_held = i_item.frame_start ? '0 : r_held_high;
        w_bad  = i_item.frame_start ? 1'b0 : r_bad_seen;

        w_expected    = 8'h00;
        w_checked     = 1'b0;
        w_last        = 1'b0;
        n_running_sum = w_sum;
        n_held_high   = w_held;

        if (w_pos < POS_W'(HEADER_LEN)) begin
            w_expected = header_byte(w_pos[2:0]);
            w_checked  = 1'b1;
        end else if (w_pos < w_csum_pos) begin
            // header length is odd, so pair high nibbles sit on odd positions
            if (w_pos[0]) begin
                n_held_high = i_item.data_byte[3:0];
            end else begin
                n_running_sum = w_sum + ({w_held, 4'h0} | i_item.data_byte);
            end
        end else if (w_pos == w_csum_pos) begin
            w_expected = (8'h00 - w_sum) & CSUM_MASK;
            w_checked  = 1'b1;
        end else begin
            // end byte, also taken when the position has run past the end
            w_expected = END_MARK;
            w_checked  = 1'b1;
            w_last     = 1'b1;
        end

        w_wrong    = w_checked && (i_item.data_byte != w_expected);
        n_bad_seen = w_bad | w_wrong;
        n_position = w_pos + 1'b1;

        if (w_last) begin
            n_position    = '0;
            n_running_sum = '0;
            n_held_high   = '0;
            n_bad_seen    = 1'b0;
        end
    end

    always_comb begin
        o_result.out_byte   = (w_wrong && i_fix_mode) ? w_expected : i_item.data_byte;
        o_result.byte_wrong = w_wrong;
        o_result.frame_last = w_last;
        o_result.frame_bad  = w_bad | w_wrong;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position    <= '0;
            r_running_sum <= '0;
            r_held_high   <= '0;
            r_bad_seen    <= 1'b0;
        end else if (i_fire) begin
            r_position    <= n_position;
            r_running_sum <= n_running_sum;
            r_held_high   <= n_held_high;
            r_bad_seen    <= n_bad_seen;
        end
    end

endmodule

// ===== src/sfc_out_reg.sv =====
// ----------------------------------------------------------------------------
// sfc_out_reg
// Result register on the master side; loads whenever it is empty or drained.
// ----------------------------------------------------------------------------
module sfc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sfc_pkg::t_result  i_result,
    output logic              o_advance,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output sfc_pkg::t_result  o_result
);
    import sfc_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_advance  = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== src/sysex_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// sysex_frame_checker_core
// Byte-wise checker for F0 44 03 00 70 00 40 sysex frames with nibble payload.
// ----------------------------------------------------------------------------
// One byte is accepted per clock unless the master side stalls, and one result
// beat leaves per byte, through the input register, then the result register.
// The header, checksum and F7 end byte are compared with their expected values;
// payload bytes pass unchecked but feed the 8-bit checksum sum. Frame length
// is 7 + payload_nibbles (clamped to 2..4096, made even) + 2 bytes. tuser on the
// slave side forces frame position zero. Write configuration only while idle.
module sysex_frame_checker_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
    input  logic                          s_axis_tuser,   // [0] frame_start
    // master side
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] out_byte
    output logic                          m_axis_tlast,   // frame_last
    output logic [1:0]                    m_axis_tuser,   // [0] byte_wrong, [1] frame_bad
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sfc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfc_pkg::*;

    logic [POS_W-1:0] r_payload_nibbles;
    logic             r_fix_mode;
    logic             r_in_valid;
    t_item            r_in_item;
    logic             w_advance;
    t_result          w_result;
    t_result          w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_nibbles <= PAYLOAD_RESET;
            r_fix_mode        <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PAYLOAD_NIBBLES: r_payload_nibbles <= i_cfg_data[POS_W-1:0];
                REG_FIX_MODE:        r_fix_mode        <= i_cfg_data[0];
                default:             ;
            endcase
        end
    end

    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.data_byte   <= s_axis_tdata;
            r_in_item.frame_start <= s_axis_tuser;
        end
    end

    sfc_frame_logic u_frame_logic (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (r_in_valid && w_advance),
        .i_item            (r_in_item),
        .i_payload_nibbles (r_payload_nibbles),
        .i_fix_mode        (r_fix_mode),
        .o_result          (w_result)
    );

    sfc_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_valid),
        .i_result   (w_result),
        .o_advance  (w_advance),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_result   (w_out)
    );

    assign m_axis_tdata = w_out.out_byte;
    assign m_axis_tlast = w_out.frame_last;
    assign m_axis_tuser = {w_out.frame_bad, w_out.byte_wrong};

endmodule

// ===== sim/sysex_frame_checker_mon.sv =====
// ----------------------------------------------------------------------------
// sysex_frame_checker_mon
// Watches the byte, result and register channels of the sysex frame checker,
// predicts each result beat from its own copy of the frame state and compares.
// ----------------------------------------------------------------------------
module sysex_frame_checker_mon (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    input  logic                           s_axis_tuser,   // [0] frame_start
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [7:0]                     m_axis_tdata,   // [7:0] out_byte
    input  logic                           m_axis_tlast,   // frame_last
    input  logic [1:0]                     m_axis_tuser,   // [0] byte_wrong, [1] frame_bad
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfc_pkg::*;

    // header bytes, position 0 in the lowest byte
    localparam logic [55:0] HDR_BYTES = 56'h40_00_70_00_03_44_F0;

    logic [POS_W-1:0] len_reg;
    logic             fix_reg;
    logic [POS_W-1:0] frm_pos;
    logic [7:0]       frm_sum;
    logic [7:0]       frm_high;
    logic             frm_bad;

    t_result          pending_bytes[$];
    t_result          got;
    t_result          want;
    int               err_cnt;
    int               res_cnt;

    // Advances the frame state by one byte and returns the result it causes.
    function automatic t_result frame_step(input logic [7:0] din, input logic sof);
        int         nib;
        int         pos;
        int         csum_at;
        logic [7:0] ref_byte;
        logic       checked;
        logic       at_end;
        t_result    r;
        nib = int'(len_reg);
        if (nib < 2) nib = 2;
        if (nib > MAX_PAYLOAD) nib = MAX_PAYLOAD;
        nib = nib & ~1;
        csum_at = HEADER_LEN + nib;
        if (sof) begin
            frm_pos  = '0;
            frm_sum  = '0;
            frm_high = '0;
            frm_bad  = 1'b0;
        end
        pos      = int'(frm_pos);
        ref_byte = '0;
        checked  = 1'b0;
        at_end   = 1'b0;
        if (pos < HEADER_LEN) begin
            ref_byte = HDR_BYTES[8*pos +: 8];
            checked  = 1'b1;
        end else if (pos < csum_at) begin
            if (((pos - HEADER_LEN) & 1) == 0)
                frm_high = din;
            else
                frm_sum = frm_sum + ({frm_high[3:0], 4'h0} | din);
        end else if (pos == csum_at) begin
            ref_byte = (8'h00 - frm_sum) & CSUM_MASK;
            checked  = 1'b1;
        end else begin
            // also covers a position left beyond the end by a shorter length
            ref_byte = END_MARK;
            checked  = 1'b1;
            at_end   = 1'b1;
        end
        r.byte_wrong = checked && (din != ref_byte);
        r.out_byte   = (r.byte_wrong && fix_reg) ? ref_byte : din;
        r.frame_last = at_end;
        frm_bad      = frm_bad | r.byte_wrong;
        r.frame_bad  = frm_bad;
        if (at_end) begin
            frm_pos  = '0;
            frm_sum  = '0;
            frm_high = '0;
            frm_bad  = 1'b0;
        end else begin
            frm_pos = frm_pos + 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            len_reg  = PAYLOAD_RESET;
            fix_reg  = 1'b1;
            frm_pos  = '0;
            frm_sum  = '0;
            frm_high = '0;
            frm_bad  = 1'b0;
            pending_bytes.delete();
        end else begin
            // compare before pushing, so a beat never meets its own prediction
            if (m_axis_tvalid && m_axis_tready) begin
                got.out_byte   = m_axis_tdata;
                got.byte_wrong = m_axis_tuser[0];
                got.frame_last = m_axis_tlast;
                got.frame_bad  = m_axis_tuser[1];
                res_cnt++;
                if (pending_bytes.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result beat: byte %02h wrong %0b last %0b bad %0b",
                             $time, got.out_byte, got.byte_wrong, got.frame_last,
                             got.frame_bad);
                end else begin
                    want = pending_bytes.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        $display("%0t: expected byte/wrong/last/bad %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                                 $time, want.out_byte, want.byte_wrong, want.frame_last,
                                 want.frame_bad, got.out_byte, got.byte_wrong,
                                 got.frame_last, got.frame_bad);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_PAYLOAD_NIBBLES: len_reg = i_cfg_data;
                    REG_FIX_MODE:        fix_reg = i_cfg_data[0];
                    default:             ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_bytes.push_back(frame_step(s_axis_tdata, s_axis_tuser));
        end
        o_pending <= pending_bytes.size();
        o_errors  <= err_cnt;
        o_results <= res_cnt;
    end

    initial begin
        err_cnt   = 0;
        res_cnt   = 0;
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
    end

endmodule

// ===== sim/sysex_frame_checker_core_test.sv =====
// ----------------------------------------------------------------------------
// sysex_frame_checker_core_test
// Drives sysex frames, broken frames and noise through the frame checker under
// changing lengths, fix mode and idling on both sides; the monitor checks.
// ----------------------------------------------------------------------------
module sysex_frame_checker_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sfc_pkg::*;

    localparam logic [55:0]          HDR_BYTES   = 56'h40_00_70_00_03_44_F0;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
    localparam int                   CYCLE_LIMIT = 400000;
    localparam int                   HOLD_CYCLES = 300;
    localparam int                   PHASE_BYTES = 160;
    localparam int                   LONG_CUT    = 40;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;
    logic [1:0]            m_axis_tuser;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int  n_errors;
    int  n_pending;
    int  n_results;
    int  tx_idle_pct  = 0;
    int  rx_idle_pct  = 0;
    bit  hold_req     = 1'b0;
    bit  hold_seen    = 1'b0;
    int  hold_left    = 0;
    int  bytes_sent   = 0;
    int  cfg_writes   = 0;
    int  frame_nibbles;

    sysex_frame_checker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    sysex_frame_checker_mon mon (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (n_errors),
        .o_pending     (n_pending),
        .o_results     (n_results)
    );

    always #4 i_clk = ~i_clk;

    // result side: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic sof);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= sof;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // register writes wait until every byte in flight has come out
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (n_pending != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic set_length(input logic [CFG_DATA_W-1:0] val);
        int n;
        cfg_write(REG_PAYLOAD_NIBBLES, val);
        n = int'(val);
        if (n < 2) n = 2;
        if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
        frame_nibbles = n & ~1;
    endtask

    // One frame of nib payload nibbles; hdr_err picks a header byte to spoil
    // (negative for none), cut stops early after that many bytes (negative: full).
    task automatic send_frame(input int nib, input int hdr_err, input bit csum_err,
                              input bit end_err, input int cut, input bit lead_sof);
        int         total;
        int         k;
        logic [7:0] b;
        logic [7:0] hi;
        logic [7:0] sum;
        total = HEADER_LEN + nib + 2;
        if (cut >= 0 && cut < total) total = cut;
        hi  = '0;
        sum = '0;
        for (k = 0; k < total; k++) begin
            if (k < HEADER_LEN) begin
                b = HDR_BYTES[8*k +: 8];
                if (k == hdr_err) b = b ^ 8'($urandom_range(1, 255));
            end else if (k < HEADER_LEN + nib) begin
                b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 15));
                if (((k - HEADER_LEN) & 1) == 0) hi = b;
                else sum = sum + ({hi[3:0], 4'h0} | b);
            end else if (k == HEADER_LEN + nib) begin
                b = (8'h00 - sum) & CSUM_MASK;
                if (csum_err) b = b ^ 8'($urandom_range(1, 255));
            end else begin
                b = END_MARK;
                if (end_err) b = b ^ 8'($urandom_range(1, 255));
            end
            send_byte(b, (k == 0) ? lead_sof : 1'b0);
        end
    endtask

    task automatic send_burst();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            send_frame(frame_nibbles, -1, $urandom_range(0, 99) < 15,
                       $urandom_range(0, 99) < 10, -1, $urandom_range(0, 99) < 85);
        end else if (r < 80) begin
            send_frame(frame_nibbles, $urandom_range(0, HEADER_LEN - 1), 1'b0, 1'b0, -1,
                       1'b1);
        end else if (r < 90) begin
            send_frame(frame_nibbles, -1, 1'b0, 1'b0,
                       $urandom_range(1, HEADER_LEN + frame_nibbles + 1), 1'b1);
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 20);
        end
    endtask

    initial begin
        int   cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("timeout after %0d cycles", cyc);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int  ph;
        int  phase_end;
        int  r;
        bit  held;
        held          = 1'b0;
        frame_nibbles = int'(PAYLOAD_RESET);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: fix mode corrects a spoilt second header byte
        send_byte(8'hF0, 1'b1);
        send_byte(8'h45, 1'b0);

        // shortest length from a zero write, fix off, spare index ignored
        set_length('0);
        cfg_write(REG_FIX_MODE, '0);
        cfg_write(REG_SPARE, '1);
        send_frame(frame_nibbles, 0, 1'b1, 1'b1, -1, 1'b1);

        // length cut mid-frame leaves the position beyond the new end
        cfg_write(REG_FIX_MODE, 13'd1);
        set_length(13'd20);
        send_frame(frame_nibbles, -1, 1'b0, 1'b0, HEADER_LEN + 4, 1'b1);
        set_length(13'd3);
        send_byte(8'h00, 1'b0);
        send_byte(8'hF0, 1'b0);

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct <= 11;
                    rx_idle_pct <= 73;
                end
                1: begin
                    tx_idle_pct <= 73;
                    rx_idle_pct <= 11;
                end
                default: begin
                    tx_idle_pct <= 0;
                    rx_idle_pct <= 0;
                end
            endcase
            if (ph == 2) begin
                // clamped longest length, from an all-ones write; frames are cut short
                set_length('1);
                cfg_write(REG_FIX_MODE, CFG_DATA_W'($urandom_range(0, 1)));
                send_frame(frame_nibbles, -1, 1'b0, 1'b0, LONG_CUT, 1'b1);
                set_length(13'd4097);
                send_frame(frame_nibbles, -1, 1'b1, 1'b0, LONG_CUT, 1'b0);
            end
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) begin
                r = $urandom_range(0, 9);
                if (r < 2)      set_length(CFG_DATA_W'($urandom_range(0, 3)));
                else if (r < 8) set_length(CFG_DATA_W'($urandom_range(4, 30)));
                else            set_length(CFG_DATA_W'($urandom_range(31, 90)));
                cfg_write(REG_FIX_MODE, CFG_DATA_W'($urandom_range(0, 1)));
                if (ph == 0 && !held) begin
                    hold_req <= ~hold_req;
                    held = 1'b1;
                end
                repeat ($urandom_range(2, 5)) send_burst();
            end
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (n_pending != 0);
        repeat (8) @(posedge i_clk);

        $display("covered %0d bytes, %0d results, %0d register writes", bytes_sent, n_results,
                 cfg_writes);
        $display("lengths 2 to 4096, fix on and off, broken frames, noise and a long stall");
        if (n_errors == 0 && n_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", n_errors, n_pending);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sfc_pkg.sv
src/sfc_frame_logic.sv
src/sfc_out_reg.sv
src/sysex_frame_checker_core.sv
sim/sysex_frame_checker_mon.sv
sim/sysex_frame_checker_core_test.sv
